### hw/rtl/pidc_pkg.sv
// Package for the two-mode PID controller: field widths, register and command codes,
// and the 48-bit saturation helper.
// It has no dependencies and is compiled first.
`default_nettype none

package pidc_pkg;

  localparam int OUT_LIMIT_DEF      = 6000;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int MEAS_W     = 24;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = MEAS_W + 1;
  localparam int OPND_W     = ERR_W + 2;
  localparam int PROD_W     = OPND_W + GAIN_W;
  localparam int ACC_W      = 48;
  localparam int SUM_W      = ACC_W + 3;
  localparam int DRIVE_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_TARGET = 3'd1,
    REG_KP     = 3'd2,
    REG_KI     = 3'd3,
    REG_KD     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_STEP  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_INC = 1'b0,
    MODE_POS = 1'b1
  } mode_t;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[ACC_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[ACC_W-1:0];
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pid_controller_two_mode_top.sv
// Two-mode fixed-point PID controller, incremental or positional.
// Depends on pidc_pkg for widths, codes and the saturation helper.
//
// Usage: one input beat per control tick carries cmd and measured. A step
// command forms the error against the target and updates the held output;
// a clear command zeroes the integral sum and repeats the current drive.
// Every input beat produces exactly one output beat with drive and limited.
// From input acceptance to output valid there is one input register, then a
// single registered pass through the three gain multipliers, the 51-bit add
// and saturation, and the output clamp. Throughput is one beat per cycle while
// the output side is not stalled.
// When the receiver asserts out_stall the output register holds its beat and
// one more item may wait in the input register; in_stall rises only when
// both are full. Registers are written through the cfg channel, which is
// always ready, and should only be written while the block is idle.
// Synchronous reset clears the registers, error history, integral sum and
// held output to zero and empties the pipeline.
`default_nettype none

module pid_controller_two_mode_top #(
  parameter int OUT_LIMIT      = pidc_pkg::OUT_LIMIT_DEF,
  parameter int GAIN_FRAC_BITS = pidc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic                                  cmd,
  input  wire logic signed [pidc_pkg::MEAS_W-1:0]    measured,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic signed [pidc_pkg::DRIVE_W-1:0]   drive,
  output      logic                                  limited,
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pidc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pidc_pkg::*;

  localparam int ACC_FRAC = 8 + GAIN_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(OUT_LIMIT) <<< ACC_FRAC;

  mode_t                    mode;
  logic signed [MEAS_W-1:0] target;
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;

  logic                     stage_valid;
  cmd_t                     stage_cmd;
  logic signed [MEAS_W-1:0] stage_meas;

  logic signed [ERR_W-1:0]  err_prev;
  logic signed [ERR_W-1:0]  err_prev2;
  logic signed [ACC_W-1:0]  integral_sum;
  logic signed [ACC_W-1:0]  held_output;

  logic signed [ERR_W-1:0]  e0;
  logic signed [OPND_W-1:0] diff1;
  logic signed [OPND_W-1:0] diff2;
  logic signed [OPND_W-1:0] p_opnd;
  logic signed [OPND_W-1:0] d_opnd;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  integral_sum_next;
  logic signed [ACC_W-1:0]  held_output_next;
  logic signed [ACC_W-1:0]  quot;
  logic signed [DRIVE_W-1:0] drive_next;
  logic                     limited_next;
  logic                     advance;
  logic                     in_take;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_INC;
      target <= '0;
      kp     <= '0;
      ki     <= '0;
      kd     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:   mode   <= mode_t'(cfg_data[0]);
        REG_TARGET: target <= cfg_data[MEAS_W-1:0];
        REG_KP:     kp     <= cfg_data[GAIN_W-1:0];
        REG_KI:     ki     <= cfg_data[GAIN_W-1:0];
        REG_KD:     kd     <= cfg_data[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    e0     = ERR_W'(target) - ERR_W'(stage_meas);
    diff1  = OPND_W'(e0) - OPND_W'(err_prev);
    diff2  = OPND_W'(e0) - (OPND_W'(err_prev) <<< 1) + OPND_W'(err_prev2);
    p_opnd = (mode == MODE_POS) ? OPND_W'(e0) : diff1;
    d_opnd = (mode == MODE_POS) ? diff1 : diff2;
    prod_p = PROD_W'(p_opnd) * PROD_W'(kp);
    prod_i = PROD_W'(e0) * PROD_W'(ki);
    prod_d = PROD_W'(d_opnd) * PROD_W'(kd);

    integral_sum_next = integral_sum;
    held_output_next  = held_output;
    if (stage_cmd == CMD_CLEAR) begin
      integral_sum_next = '0;
    end else if (mode == MODE_POS) begin
      integral_sum_next = sat48(SUM_W'(integral_sum) + SUM_W'(prod_i));
      held_output_next  = sat48(SUM_W'(prod_p) + SUM_W'(integral_sum_next)
                                + SUM_W'(prod_d));
    end else begin
      held_output_next  = sat48(SUM_W'(held_output) + SUM_W'(prod_p)
                                + SUM_W'(prod_i) + SUM_W'(prod_d));
    end

    quot = held_output_next >>> ACC_FRAC;
    if (held_output_next[ACC_W-1] && (|held_output_next[ACC_FRAC-1:0])) begin
      quot = quot + ACC_W'(1);
    end
    if (held_output_next >= LIM) begin
      drive_next   = DRIVE_W'(OUT_LIMIT);
      limited_next = 1'b1;
    end else if (held_output_next <= -LIM) begin
      drive_next   = -DRIVE_W'(OUT_LIMIT);
      limited_next = 1'b1;
    end else begin
      drive_next   = quot[DRIVE_W-1:0];
      limited_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_cmd  <= cmd_t'(cmd);
      stage_meas <= measured;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_prev     <= '0;
      err_prev2    <= '0;
      integral_sum <= '0;
      held_output  <= '0;
    end else if (advance) begin
      integral_sum <= integral_sum_next;
      held_output  <= held_output_next;
      if (stage_cmd == CMD_STEP) begin
        err_prev2 <= err_prev;
        err_prev  <= e0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive   <= drive_next;
      limited <= limited_next;
    end
  end

endmodule

`default_nettype wire

### tb/sv/pid_controller_two_mode_top_tb.sv
// Self-checking testbench for pid_controller_two_mode_top: random and directed beats
// are checked against an in-bench model of both PID modes. Depends on pidc_pkg and the RTL.
module pid_controller_two_mode_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;

  localparam int  MEAS_FRAC   = 8;
  localparam int  ACC_FRAC    = MEAS_FRAC + GAIN_FRAC_BITS_DEF;
  localparam int  DRIVE_LIMIT = OUT_LIMIT_DEF;
  localparam int  QUIET_LIMIT = 3000;
  localparam longint ACC_MAX  = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN  = -ACC_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  typedef struct packed {
    cmd_t              c;
    logic [MEAS_W-1:0] m;
  } step_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      limited;
  } drive_beat_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       cmd = 1'b0;
  logic signed [MEAS_W-1:0]   measured = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]  drive;
  logic                       limited;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  step_t       step_queue[$];
  drive_beat_t drive_expected[$];
  step_t       next_step;
  drive_beat_t want;
  int          steps_queued = 0;
  int          steps_accepted = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_gap_pct = 32;
  int          recv_stall_pct = 61;

  mode_t  cfg_mode = MODE_INC;
  longint set_point = 0;
  longint gain_p = 0;
  longint gain_i = 0;
  longint gain_d = 0;
  longint err_last = 0;
  longint err_before = 0;
  longint integ_acc = 0;
  longint out_acc = 0;

  pid_controller_two_mode_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .measured  (measured),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .limited   (limited),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clip48(longint v);
    if (v > ACC_MAX) begin
      return ACC_MAX;
    end
    if (v < ACC_MIN) begin
      return ACC_MIN;
    end
    return v;
  endfunction

  function automatic drive_beat_t pid_tick(cmd_t c, logic signed [MEAS_W-1:0] meas);
    longint      e0;
    longint      lim;
    drive_beat_t r;
    lim = longint'(DRIVE_LIMIT) <<< ACC_FRAC;
    if (c == CMD_CLEAR) begin
      integ_acc = 0;
    end else begin
      e0 = set_point - longint'(meas);
      if (cfg_mode == MODE_INC) begin
        out_acc = clip48(out_acc + gain_p * (e0 - err_last) + gain_i * e0
                         + gain_d * (e0 - 2 * err_last + err_before));
      end else begin
        integ_acc = clip48(integ_acc + gain_i * e0);
        out_acc   = clip48(gain_p * e0 + integ_acc + gain_d * (e0 - err_last));
      end
      err_before = err_last;
      err_last   = e0;
    end
    if (out_acc >= lim) begin
      r.drive   = DRIVE_W'(DRIVE_LIMIT);
      r.limited = 1'b1;
    end else if (out_acc <= -lim) begin
      r.drive   = DRIVE_W'(-DRIVE_LIMIT);
      r.limited = 1'b1;
    end else begin
      r.drive   = DRIVE_W'(out_acc / (longint'(1) <<< ACC_FRAC));
      r.limited = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) begin
      return $urandom_range(1) ? 16'h7fff : 16'h8000;
    end
    if (r < 3) begin
      return GAIN_W'($urandom);
    end
    return GAIN_W'(int'($urandom_range(2047)) - 1024);
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic add_item(cmd_t c, logic [MEAS_W-1:0] m);
    step_t s;
    s.c = c;
    s.m = m;
    step_queue.push_back(s);
    steps_queued++;
  endtask

  task automatic drain_pipeline();
    while (steps_accepted != steps_queued || drive_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:   cfg_mode  = mode_t'(data[0]);
      REG_TARGET: set_point = longint'($signed(data));
      REG_KP:     gain_p    = longint'($signed(data[GAIN_W-1:0]));
      REG_KI:     gain_i    = longint'($signed(data[GAIN_W-1:0]));
      REG_KD:     gain_d    = longint'($signed(data[GAIN_W-1:0]));
      default: ;
    endcase
  endtask

  // Sender side: a stalled beat is held until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (step_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        next_step = step_queue.pop_front();
        in_valid <= 1'b1;
        cmd      <= next_step.c;
        measured <= next_step.m;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (drive_expected.size() == 0) begin
          note_mismatch($sformatf("drive beat %0d with nothing expected", drive));
        end else begin
          want = drive_expected.pop_front();
          if (drive !== want.drive) begin
            note_mismatch($sformatf("drive %0d, expected %0d", drive, want.drive));
          end
          if (limited !== want.limited) begin
            note_mismatch($sformatf("limited %b, expected %b", limited, want.limited));
          end
        end
      end
      if (in_valid && !in_stall) begin
        drive_expected.push_back(pid_tick(cmd_t'(cmd), measured));
        steps_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pid_controller_two_mode_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int               n;
    int unsigned      r;
    logic [MEAS_W-1:0] tgt;
    logic [MEAS_W-1:0] m;
    logic             sat_up;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // All registers still at their reset values.
    add_item(CMD_STEP, 24'h000000);
    add_item(CMD_CLEAR, 24'h5a5a5a);

    // Unity proportional gain around the drive limit; a write to a spare index must not land.
    drain_pipeline();
    set_register(REG_MODE, {23'd0, MODE_POS});
    set_register(REG_KP, {8'h00, 16'd256});
    set_register(REG_TARGET, 24'd0);
    set_register(REG_SPARE, 24'h001234);
    add_item(CMD_STEP, 24'(-1536000));
    add_item(CMD_STEP, 24'(-1535999));
    add_item(CMD_STEP, 24'(1535999));
    add_item(CMD_STEP, 24'(1536000));
    add_item(CMD_STEP, 24'(1));
    add_item(CMD_STEP, 24'h800000);
    add_item(CMD_STEP, 24'h7fffff);

    // Gain extremes, a clear of the integral, then a switch to incremental mode.
    drain_pipeline();
    set_register(REG_TARGET, 24'h7fffff);
    set_register(REG_KP, {8'hff, 16'h8000});
    set_register(REG_KI, {8'h00, 16'h7fff});
    set_register(REG_KD, {8'ha5, 16'h7fff});
    add_item(CMD_STEP, 24'h800000);
    add_item(CMD_STEP, 24'h000000);
    add_item(CMD_STEP, 24'h7fffff);
    add_item(CMD_CLEAR, 24'hffffff);
    add_item(CMD_STEP, 24'h001000);
    drain_pipeline();
    set_register(REG_MODE, {23'h7fffff, MODE_INC});
    add_item(CMD_STEP, 24'h7fffff);
    add_item(CMD_STEP, 24'h800000);
    add_item(CMD_CLEAR, 24'h000000);
    add_item(CMD_STEP, 24'd100);
    drain_pipeline();
    set_register(REG_TARGET, 24'h800000);
    set_register(REG_KP, {8'h00, 16'd1});
    set_register(REG_KI, {8'h00, 16'hffff});
    set_register(REG_KD, 24'd0);
    add_item(CMD_STEP, 24'h800300);
    add_item(CMD_STEP, 24'h800000);

    for (int phase = 0; phase < 3; phase++) begin
      drain_pipeline();
      send_gap_pct   <= (phase == 0) ? 32 : (phase == 1) ? 61 : 0;
      recv_stall_pct <= (phase == 0) ? 61 : (phase == 1) ? 32 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        drain_pipeline();
        r = $urandom_range(3);
        tgt = (r == 0) ? MEAS_W'($urandom) : MEAS_W'(int'($urandom_range(8191)) - 4096);
        set_register(REG_MODE, CFG_DATA_W'($urandom));
        set_register(REG_TARGET, tgt);
        set_register(REG_KP, {8'($urandom), pick_gain()});
        set_register(REG_KI, {8'($urandom), pick_gain()});
        set_register(REG_KD, {8'($urandom), pick_gain()});
        set_register(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_SPARE)),
                     CFG_DATA_W'($urandom));
        n = $urandom_range(24, 12);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(9);
          if (r == 0) begin
            add_item(CMD_CLEAR, MEAS_W'($urandom));
          end else if (r < 3) begin
            add_item(CMD_STEP, MEAS_W'($urandom));
          end else begin
            add_item(CMD_STEP, MEAS_W'(int'($signed(tgt)) + int'($urandom_range(32767)) - 16384));
          end
        end
      end

      if (phase == 1) begin
        // Drive the integral sum and held output into saturation, then carry on incrementally.
        drain_pipeline();
        sat_up = 1'($urandom);
        set_register(REG_MODE, {23'($urandom), MODE_POS});
        set_register(REG_TARGET, sat_up ? 24'h7fffff : 24'h800000);
        set_register(REG_KI, {8'($urandom), 16'h7fff});
        set_register(REG_KP, {8'($urandom), pick_gain()});
        set_register(REG_KD, {8'($urandom), pick_gain()});
        add_item(CMD_CLEAR, MEAS_W'($urandom));
        for (int k = 0; k < 295; k++) begin
          if (k == 270) begin
            drain_pipeline();
            set_register(REG_MODE, {23'($urandom), MODE_INC});
          end
          m = (sat_up ^ (k >= 285)) ? {1'b1, 7'h00, 16'($urandom)} : {1'b0, 7'h7f, 16'($urandom)};
          add_item(CMD_STEP, m);
        end
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("pid_controller_two_mode_top_tb OK");
    end else begin
      $display("pid_controller_two_mode_top_tb NOT OK");
    end
    $finish;
  end

endmodule
